/* sv/sobel_gradient_magnitude_unit_macros.svh */
// Assertion helpers for the Sobel magnitude unit
`ifndef SOBEL_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH

// implication checked on every clock, off during reset
`define SGM_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");

// next-cycle implication
`define SGM_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");

`endif

/* sv/sgm_pkg.sv */
package sgm_pkg;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int HEIGHT_CAP    = 4096;
	localparam logic [10:0] WIDTH_RESET  = 11'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take_pixel;
		logic start_root;
		logic root_step;
		logic load_out;
		logic restart;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic interior;
		logic root_done;
	} sts_t;
endpackage

/* sv/sgm_ctrl.sv */
module sgm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          out_free,
	input  logic          restart,
	input  sgm_pkg::sts_t sts,
	output sgm_pkg::cmd_t cmd,
	output logic          in_ready
);
	sgm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sgm_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sgm_pkg::ST_IDLE: begin
				if (in_valid && sts.interior) state_d = sgm_pkg::ST_ROOT;
			end
			sgm_pkg::ST_ROOT: begin
				if (sts.root_done) state_d = sgm_pkg::ST_OUT;
			end
			sgm_pkg::ST_OUT: begin
				if (out_free) state_d = sgm_pkg::ST_IDLE;
			end
			default: state_d = sgm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		cmd.restart = restart;
		case (state_q)
			sgm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take_pixel = in_valid;
				cmd.start_root = in_valid && sts.interior;
			end
			sgm_pkg::ST_ROOT: cmd.root_step = 1'b1;
			sgm_pkg::ST_OUT:  cmd.load_out = out_free;
			default: ;
		endcase
	end
endmodule

/* sv/sgm_datapath.sv */
module sgm_datapath #(
	parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sgm_pkg::cmd_t cmd,
	input  logic [7:0]    pixel,
	input  logic [10:0]   frame_width,
	input  logic [12:0]   frame_height,
	input  logic          out_taken,
	output sgm_pkg::sts_t sts,
	output logic          out_valid,
	output logic [10:0]   magnitude,
	output logic [11:0]   out_row,
	output logic [9:0]    out_col,
	output logic          frame_last
);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [7:0] upper_mem [MAX_WIDTH];
	logic [7:0] middle_mem [MAX_WIDTH];
	logic [7:0] win_q [3][3];
	logic [CW-1:0] col_q;
	logic [11:0] row_q;

	logic [CW-1:0] w_eff;
	logic [11:0] hm1;
	logic [7:0] up, mid;
	logic in_range;
	logic [AW-1:0] addr;
	logic [CW-1:0] col_d;
	logic [AW-1:0] rd_addr;

	always_comb begin
		if (frame_width < 11'd3) w_eff = CW'(3);
		else if ({21'd0, frame_width} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(frame_width);
		if (frame_height < 13'd3) hm1 = 12'd2;
		else if (frame_height > 13'(sgm_pkg::HEIGHT_CAP)) hm1 = 12'd4095;
		else hm1 = 12'(frame_height - 13'd1);
	end

	// column after this edge; the stores are read there in advance, into up and mid
	always_comb begin
		if (cmd.restart) col_d = '0;
		else if (cmd.take_pixel) col_d = (col_q >= w_eff - CW'(1)) ? '0 : col_q + CW'(1);
		else col_d = col_q;
	end

	assign in_range = {{(32-CW){1'b0}}, col_q} < 32'(MAX_WIDTH);
	assign addr = col_q[AW-1:0];
	assign rd_addr = col_d[AW-1:0];

	// unwritten entries only reach border windows, so no clearing
	always_ff @(posedge clk) begin
		if (cmd.take_pixel && in_range) begin
			upper_mem[addr]  <= mid;
			middle_mem[addr] <= pixel;
		end
		up  <= upper_mem[rd_addr];
		mid <= middle_mem[rd_addr];
	end

	assign sts.interior = row_q >= 12'd2 && col_q >= CW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
		end else if (cmd.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.take_pixel) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= in_range ? up : 8'd0;
			win_q[1][2] <= in_range ? mid : 8'd0;
			win_q[2][2] <= pixel;
			if (col_q >= w_eff - CW'(1)) begin
				col_q <= '0;
				row_q <= (row_q >= hm1) ? 12'd0 : row_q + 12'd1;
			end else col_q <= col_q + CW'(1);
		end
	end

	// gradient sums from the new window (pre-shift taps plus incoming column)
	logic signed [11:0] gx, gy;
	logic [7:0] a00, a01, a10, a20, a21, n0, n1, n2;
	always_comb begin
		a00 = win_q[0][1]; a01 = win_q[0][2];
		a10 = win_q[1][1];
		a20 = win_q[2][1]; a21 = win_q[2][2];
		n0 = in_range ? up : 8'd0;
		n1 = in_range ? mid : 8'd0;
		n2 = pixel;
		gx = $signed({4'd0, n0}) + $signed({3'd0, n1, 1'b0}) + $signed({4'd0, n2})
		   - $signed({4'd0, a00}) - $signed({3'd0, a10, 1'b0}) - $signed({4'd0, a20});
		gy = $signed({4'd0, a20}) + $signed({3'd0, a21, 1'b0}) + $signed({4'd0, n2})
		   - $signed({4'd0, a00}) - $signed({3'd0, a01, 1'b0}) - $signed({4'd0, n0});
	end

	// stage 1: squares; then a two-bit-per-cycle restoring root
	logic [21:0] sqx_s1, sqy_s1;
	logic [11:0] row_s1;
	logic [9:0] col_s1;
	logic last_s1;
	logic [11:0] rem_q;
	logic [10:0] res_q;
	logic [3:0] step_q;
	logic sum_ph_q;
	logic [23:0] rad_q;

	logic [23:0] trial;
	logic [13:0] rem_hi;
	always_comb begin
		rem_hi = {rem_q, rad_q[23:22]};
		trial = 24'(rem_hi) - {11'd0, res_q, 2'b01};
	end

	always_ff @(posedge clk) begin
		if (cmd.start_root) begin
			sqx_s1 <= 22'(24'(gx) * 24'(gx));
			sqy_s1 <= 22'(24'(gy) * 24'(gy));
			row_s1 <= row_q - 12'd1;
			col_s1 <= 10'(col_q - CW'(1));
			last_s1 <= (row_q == hm1) && (col_q == w_eff - CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			sum_ph_q <= 1'b0;
		end else if (cmd.start_root) begin
			sum_ph_q <= 1'b1;
			step_q <= '0;
		end else if (cmd.root_step) begin
			if (sum_ph_q) begin
				sum_ph_q <= 1'b0;
				rad_q <= {2'b00, sqx_s1} + {2'b00, sqy_s1};
				rem_q <= '0;
				res_q <= '0;
			end else begin
				step_q <= step_q + 4'd1;
				rad_q <= {rad_q[21:0], 2'b00};
				if (!trial[23]) begin
					rem_q <= 12'(trial);
					res_q <= {res_q[9:0], 1'b1};
				end else begin
					rem_q <= 12'(rem_hi);
					res_q <= {res_q[9:0], 1'b0};
				end
			end
		end
	end

	// 23-bit radicand padded to 24: twelve steps; result fits 11 bits
	assign sts.root_done = cmd.root_step && !sum_ph_q && step_q == 4'd11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.load_out) out_valid <= 1'b1;
		else if (out_taken) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			magnitude  <= res_q;
			out_row    <= row_s1;
			out_col    <= col_s1;
			frame_last <= last_s1;
		end
	end
endmodule

/* sv/sobel_gradient_magnitude_unit.sv */
// Sobel edge magnitude over a 3x3 window. Pixels enter in raster order on
// s_axis, one byte each; for every interior pixel (not on the frame's border
// rows or columns) one word leaves on m_axis carrying floor(sqrt(gx^2+gy^2)),
// the pixel's row and column and a frame-last flag in tlast. Border pixels
// produce nothing and leave the unit idle. After an interior pixel the unit,
// with s_axis not ready, computes the squares, their sum, twelve steps of
// the two-bit-a-cycle square root, then loads the output register once
// m_axis is free. Writing either APB register restarts the frame at row 0,
// column 0. Width is clamped to 3..MAX_WIDTH, height to 3..4096.
module sobel_gradient_magnitude_unit #(
	parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] pixel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [10:0] magnitude, [22:11] out_row, [32:23] out_col
	output logic        m_axis_tlast
);
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic wr;
	sgm_pkg::cmd_t cmd;
	sgm_pkg::sts_t sts;
	logic [10:0] mag;
	logic [11:0] orow;
	logic [9:0] ocol;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sgm_pkg::WIDTH_RESET[10:0];
			height_q <= sgm_pkg::HEIGHT_RESET;
		end else if (wr && paddr[2] == sgm_pkg::REG_WIDTH) begin
			width_q <= pwdata[10:0];
		end else if (wr && paddr[2] == sgm_pkg::REG_HEIGHT) begin
			height_q <= pwdata[12:0];
		end
	end

	always_comb begin
		if (paddr[2] == sgm_pkg::REG_WIDTH) prdata = {21'd0, width_q};
		else prdata = {19'd0, height_q};
	end

	sgm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.out_free(!m_axis_tvalid || m_axis_tready),
		.restart(wr),
		.sts(sts), .cmd(cmd),
		.in_ready(s_axis_tready)
	);

	sgm_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.pixel(s_axis_tdata),
		.frame_width(width_q), .frame_height(height_q),
		.out_taken(m_axis_tready),
		.sts(sts), .out_valid(m_axis_tvalid),
		.magnitude(mag), .out_row(orow), .out_col(ocol),
		.frame_last(m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, ocol, orow, mag};
endmodule

/* sv/sgm_checker.sv */
`include "sobel_gradient_magnitude_unit_macros.svh"
module sgm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	`SGM_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)
	`SGM_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`SGM_ASSERT_IMP(a_mag, clk, arst_n, m_axis_tvalid, m_axis_tdata[10:0] <= 11'd1442)
	`SGM_ASSERT_IMP(a_row, clk, arst_n, m_axis_tvalid, m_axis_tdata[22:11] != 12'd0)
endmodule

bind sobel_gradient_magnitude_unit sgm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .pready(pready),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

/* sim/sobel_gradient_magnitude_unit_check.sv */
module sobel_gradient_magnitude_unit_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [10:0] magnitude;
		logic [11:0] out_row;
		logic [9:0]  out_col;
		logic        frame_last;
	} edge_word_t;

	logic [7:0]  upper_line [1024];
	logic [7:0]  middle_line [1024];
	logic [7:0]  win [3][3];
	logic [10:0] width_reg;
	logic [12:0] height_reg;
	int unsigned col_pos, row_pos;
	edge_word_t  magnitudes_due [$];

	assign pending = magnitudes_due.size();

	function automatic int unsigned int_sqrt(int unsigned v);
		int unsigned res, bitv;
		res = 0;
		bitv = 1 << 30;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	task automatic take_pixel(input logic [7:0] p);
		int unsigned w, h;
		int gx, gy;
		logic [7:0] up, mid;
		edge_word_t e;
		w = (width_reg < 3) ? 3 : (width_reg > 1024) ? 1024 : width_reg;
		h = (height_reg < 3) ? 3 : (height_reg > 4096) ? 4096 : height_reg;
		up = upper_line[col_pos];
		mid = middle_line[col_pos];
		upper_line[col_pos] = mid;
		middle_line[col_pos] = p;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = p;
		if (row_pos >= 2 && col_pos >= 2) begin
			gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
			gy = (win[2][0] + 2 * win[2][1] + win[2][2]) - (win[0][0] + 2 * win[0][1] + win[0][2]);
			e.magnitude = 11'(int_sqrt(gx * gx + gy * gy));
			e.out_row = 12'(row_pos - 1);
			e.out_col = 10'(col_pos - 1);
			e.frame_last = (row_pos == h - 1 && col_pos == w - 1);
			magnitudes_due.push_back(e);
		end
		if (col_pos >= w - 1) begin
			col_pos = 0;
			row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_word_t got, want;
		if (!arst_n) begin
			width_reg = 11'd640;
			height_reg = 13'd480;
			col_pos = 0;
			row_pos = 0;
			fail_count = 0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) win[r][c] = '0;
			for (int i = 0; i < 1024; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == 1'b0) begin
					width_reg = pwdata[10:0];
					col_pos = 0;
					row_pos = 0;
				end else begin
					height_reg = pwdata[12:0];
					col_pos = 0;
					row_pos = 0;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.magnitude = m_axis_tdata[10:0];
				got.out_row = m_axis_tdata[22:11];
				got.out_col = m_axis_tdata[32:23];
				got.frame_last = m_axis_tlast;
				if (magnitudes_due.size() == 0) begin
					$error("unexpected word: magnitude %0d row %0d col %0d",
						got.magnitude, got.out_row, got.out_col);
					fail_count++;
				end else begin
					want = magnitudes_due.pop_front();
					if (got.magnitude !== want.magnitude) begin
						$error("magnitude: expected %0d actual %0d", want.magnitude, got.magnitude);
						fail_count++;
					end
					if (got.out_row !== want.out_row) begin
						$error("out_row: expected %0d actual %0d", want.out_row, got.out_row);
						fail_count++;
					end
					if (got.out_col !== want.out_col) begin
						$error("out_col: expected %0d actual %0d", want.out_col, got.out_col);
						fail_count++;
					end
					if (got.frame_last !== want.frame_last) begin
						$error("frame_last: expected %0d actual %0d", want.frame_last,
							got.frame_last);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata);
		end
	end
endmodule

/* sim/sobel_gradient_magnitude_unit_test.sv */
module sobel_gradient_magnitude_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        s_axis_tvalid, s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] pixel
	logic        m_axis_tvalid, m_axis_tready;
	logic [39:0] m_axis_tdata;   // [10:0] magnitude, [22:11] out_row, [32:23] out_col
	logic        m_axis_tlast;
	int          fail_count, pending;
	bit          rx_relax;

	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	sobel_gradient_magnitude_unit DUT (.*);

	sobel_gradient_magnitude_unit_check checker_i (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// generous bound: each interior pixel holds the unit through its root, plus stalls
	initial begin
		#400ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// sink: random stall before each word, none while relaxed
	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = rx_relax ? 0 : $urandom_range(13);
			m_axis_tready = 0;
			repeat (gap) @(negedge clk);
			m_axis_tready = 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
		@(negedge clk);
		psel = 1; pwrite = 1; paddr = addr; pwdata = val; penable = 0;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	// wait for the queue to empty, then let the root pipeline drain
	task automatic settle;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] p, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(13);
		repeat (gap) @(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tdata = p;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic run_frame(input int w, input int h, input int kind);
		bit burst;
		logic [7:0] p;
		burst = ($urandom_range(3) == 0);
		for (int i = 0; i < w * h; i++) begin
			case (kind)
				0: p = 8'($urandom);
				1: p = ((i % w) & 1) ? 8'hFF : 8'h00;   // vertical stripes
				2: p = ((i / w) & 1) ? 8'hFF : 8'h00;   // horizontal stripes
				default: p = $urandom_range(1) ? 8'hFF : 8'h00;
			endcase
			send_pixel(p, burst);
		end
	endtask

	initial begin
		int w, h;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0;
		rx_relax = 0;
		arst_n = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;

		// directed: smallest frame, saturating extremes
		reg_write(ADDR_WIDTH, 3);
		reg_write(ADDR_HEIGHT, 3);
		for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'h00 : 8'hFF, 0);
		for (int i = 0; i < 9; i++) send_pixel((i < 3) ? 8'h00 : 8'hFF, 0);
		settle();
		// out-of-range values clamp to 3 (width 0, height 1)
		reg_write(ADDR_WIDTH, 0);
		reg_write(ADDR_HEIGHT, 1);
		run_frame(3, 3, 3);
		settle();
		// all-ones register data: width clamps to max, part of a first row only
		reg_write(ADDR_WIDTH, 32'hFFFF_FFFF);
		reg_write(ADDR_HEIGHT, 32'hFFFF_FFFF);
		for (int i = 0; i < 100; i++) send_pixel(8'($urandom), 0);
		settle();
		// restart mid-frame by a write
		reg_write(ADDR_WIDTH, 4);
		reg_write(ADDR_HEIGHT, 4);
		for (int i = 0; i < 7; i++) send_pixel(8'($urandom), 0);
		settle();
		reg_write(ADDR_HEIGHT, 4);

		// pause until drained, sink kept ready
		run_frame(4, 4, 1);
		rx_relax = 1;
		settle();
		rx_relax = 0;

		for (int f = 0; f < 26; f++) begin
			w = $urandom_range(3, 8);
			h = $urandom_range(3, 7);
			if (f == 20) h = 4096;  // a tall frame at minimum width, partly sent
			reg_write(ADDR_WIDTH, w);
			reg_write(ADDR_HEIGHT, h);
			if (f == 20) begin
				w = 3;
				reg_write(ADDR_WIDTH, 3);
				run_frame(3, 8, 0);
			end else begin
				run_frame(w, h, $urandom_range(3));
				if ($urandom_range(1)) run_frame(w, h, 0);  // back-to-back frames
			end
			settle();
		end

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
